// File: hdl/mwpb_pkg.sv
// ----------------------------------------------------------------------------
// mwpb_pkg
// Shared types and constants of the mask wipe pixel blend.
// ----------------------------------------------------------------------------
package mwpb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 4;
  localparam int unsigned PixW    = ChanW * NumChan;
  localparam int unsigned PctW    = 11;
  localparam int unsigned GainW   = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = PctW;

  // progress * (gain + 1) for progress 1..99
  localparam int unsigned ScaleW  = 13;
  // scaled progress, 0..256 * 64
  localparam int unsigned FullW   = GainW + 1 + ChanW;
  localparam int unsigned OffW    = FullW + 1;
  localparam int unsigned MgW     = ChanW + GainW;
  localparam int unsigned SumW    = MgW + 3;

  // floor(64 * x / 25) == (x * RecipMul) >> RecipShift for x below 2**13
  localparam int unsigned ProdW      = 33;
  localparam int unsigned RecipShift = 18;
  localparam logic [ProdW-1:0] RecipMul = 33'd671089;

  localparam logic [PctW-1:0] PctFull = 11'd100;
  localparam logic signed [OffW-1:0] OffsetRst = -16'sd256;

  typedef enum logic [CfgIdxW-1:0] {
    CfgProgress = 1'b0,
    CfgGain     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]       gain;
    logic signed [OffW-1:0] offset;
  } frame_cfg_t;

endpackage

// File: hdl/mask_wipe_pixel_blend.sv
// ----------------------------------------------------------------------------
// mask_wipe_pixel_blend
// Rule mask transition blend of one packed four-channel pixel per clock.
// ----------------------------------------------------------------------------
// the result strobe follows the input, mask gain, weight, blend product and output registers
// throughput: one transaction per clock through the five register stages
// busy is held low: the pipeline never stalls and results are not held
// reset: progress 0, gain 1, offset preset to match, pipeline empty
// offset follows a config write through the pct, stage a and offset registers, before a next item needs it
module mask_wipe_pixel_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mwpb_pkg::PixW-1:0]     start_pixel_i,
  input  logic [mwpb_pkg::PixW-1:0]     end_pixel_i,
  input  logic [mwpb_pkg::PixW-1:0]     mask_pixel_i,
  output logic                          result_valid_o,
  output logic [mwpb_pkg::PixW-1:0]     blended_pixel_o,
  input  logic                          cfg_we_i,
  input  logic [mwpb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mwpb_pkg::CfgW-1:0]     cfg_wdata_i
);
  import mwpb_pkg::*;

  frame_cfg_t       frame_cfg;
  logic             accept;
  logic [3:0]       vld_q, vld_d;
  logic             out_vld_q;
  logic [PixW-1:0]  sp_q, ep_q, mp_q;
  logic [PixW-1:0]  blend;
  logic [PixW-1:0]  out_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign vld_d  = {vld_q[2:0], accept};

  mwpb_offset u_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_cfg_o (frame_cfg)
  );

  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    mwpb_lane u_lane (
      .clk_i       (clk_i),
      .frame_cfg_i (frame_cfg),
      .start_ch_i  (sp_q[c*ChanW +: ChanW]),
      .end_ch_i    (ep_q[c*ChanW +: ChanW]),
      .mask_ch_i   (mp_q[c*ChanW +: ChanW]),
      .blend_ch_o  (blend[c*ChanW +: ChanW])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q  <= start_pixel_i;
    ep_q  <= end_pixel_i;
    mp_q  <= mask_pixel_i;
    out_q <= blend;
  end

  assign result_valid_o  = out_vld_q;
  assign blended_pixel_o = out_q;

endmodule

// File: hdl/mwpb_offset.sv
// ----------------------------------------------------------------------------
// mwpb_offset
// Configuration registers and the two-stage per-frame offset pipeline.
// ----------------------------------------------------------------------------
module mwpb_offset (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mwpb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mwpb_pkg::CfgW-1:0]        cfg_wdata_i,
  output mwpb_pkg::frame_cfg_t             frame_cfg_o
);
  import mwpb_pkg::*;

  logic [PctW-1:0]        pct_q, pct_d;
  logic [GainW-1:0]       gain_q, gain_d;
  logic [ScaleW-1:0]      x_q, x_d;
  logic                   pos_q, pos_d;
  logic                   full_q, full_d;
  logic signed [OffW-1:0] offset_q, offset_d;
  logic [GainW:0]         gain_p1;
  logic [ProdW-1:0]       quot_prod;
  logic [FullW-1:0]       quot;
  logic [FullW-1:0]       full_span;
  logic [FullW-1:0]       scaled;

  always_comb begin
    pct_d  = pct_q;
    gain_d = gain_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgProgress: pct_d  = cfg_wdata_i;
        CfgGain:     gain_d = cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // stage a: sign and range of progress, small product
  always_comb begin
    gain_p1 = {1'b0, gain_q} + (GainW+1)'(1);
    pos_d   = !pct_q[PctW-1] && (pct_q != '0);
    full_d  = !pct_q[PctW-1] && (pct_q >= PctFull);
    x_d     = ScaleW'(pct_q[6:0] * gain_p1);
  end

  // stage b: divide by 100 through reciprocal, clamp, remove gain span
  always_comb begin
    quot_prod = ProdW'(x_q) * RecipMul;
    quot      = quot_prod[RecipShift +: FullW];
    full_span = {gain_p1, {ChanW{1'b0}}};
    if (!pos_q) begin
      scaled = '0;
    end else if (full_q) begin
      scaled = full_span;
    end else begin
      scaled = quot;
    end
    offset_d = $signed({1'b0, scaled}) - $signed({2'b00, gain_q, {ChanW{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q    <= '0;
      gain_q   <= GainW'(1);
      x_q      <= '0;
      pos_q    <= 1'b0;
      full_q   <= 1'b0;
      offset_q <= OffsetRst;
    end else begin
      pct_q    <= pct_d;
      gain_q   <= gain_d;
      x_q      <= x_d;
      pos_q    <= pos_d;
      full_q   <= full_d;
      offset_q <= offset_d;
    end
  end

  assign frame_cfg_o.gain   = gain_q;
  assign frame_cfg_o.offset = offset_q;

endmodule

// File: hdl/mwpb_lane.sv
// ----------------------------------------------------------------------------
// mwpb_lane
// One channel: mask gain product, clamped weight, blend products, sum.
// ----------------------------------------------------------------------------
module mwpb_lane (
  input  logic                        clk_i,
  input  mwpb_pkg::frame_cfg_t        frame_cfg_i,
  input  logic [mwpb_pkg::ChanW-1:0]  start_ch_i,
  input  logic [mwpb_pkg::ChanW-1:0]  end_ch_i,
  input  logic [mwpb_pkg::ChanW-1:0]  mask_ch_i,
  output logic [mwpb_pkg::ChanW-1:0]  blend_ch_o
);
  import mwpb_pkg::*;

  logic [MgW-1:0]         mg_q, mg_d;
  logic [ChanW-1:0]       s2_q, e2_q;
  logic [ChanW-1:0]       w_q, w_d;
  logic [ChanW-1:0]       s3_q, e3_q;
  logic signed [SumW-1:0] w_sum;
  logic [ChanW:0]         inv_w;
  logic [2*ChanW-1:0]     ps_q, ps_d;
  logic [2*ChanW-1:0]     pe_q, pe_d;
  logic [2*ChanW-1:0]     total;

  assign mg_d = MgW'(mask_ch_i * frame_cfg_i.gain);

  always_comb begin
    w_sum = $signed({3'b000, mg_q}) + SumW'(frame_cfg_i.offset);
    if (w_sum < 0) begin
      w_d = '0;
    end else if (w_sum > $signed(SumW'(255))) begin
      w_d = '1;
    end else begin
      w_d = w_sum[ChanW-1:0];
    end
  end

  always_comb begin
    inv_w = (ChanW+1)'(256) - {1'b0, w_q};
    ps_d  = (2*ChanW)'(s3_q * inv_w);
    pe_d  = (2*ChanW)'(e3_q * w_q);
  end

  assign total      = ps_q + pe_q;
  assign blend_ch_o = total[2*ChanW-1:ChanW];

  always_ff @(posedge clk_i) begin
    mg_q <= mg_d;
    s2_q <= start_ch_i;
    e2_q <= end_ch_i;
    w_q  <= w_d;
    s3_q <= s2_q;
    e3_q <= e2_q;
    ps_q <= ps_d;
    pe_q <= pe_d;
  end

endmodule
